[rtl/core/fmjr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feed motor jam recovery package
// Shared constants, codes and the command record that passes from the
// classifying front end to the setpoint back end.
// ----------------------------------------------------------------------------
package fmjr_pkg;

    localparam int WINDOW_LEN_DEF = 10;

    localparam int THR_W  = 15;
    localparam int TICKS_W = 8;
    localparam int STEP_W = 10;
    localparam int CNT_W  = 8;
    localparam int POS_W  = 32;
    localparam int ADV_W  = STEP_W + CNT_W;

    localparam logic [THR_W-1:0]   JAM_THRESHOLD_RST  = 15'd6000;
    localparam logic [TICKS_W-1:0] RECOVERY_TICKS_RST = 8'd25;
    localparam logic [STEP_W-1:0]  SLOT_STEP_RST      = 10'd18;
    localparam logic [STEP_W-1:0]  RETURN_STEP_RST    = 10'd9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_BURST = 2'd1,
        KIND_SHOT  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_JAM_THRESHOLD  = 2'd0,
        REG_RECOVERY_TICKS = 2'd1,
        REG_SLOT_STEP      = 2'd2,
        REG_RETURN_STEP    = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_ADVANCE = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic               over;      // window magnitude above the jam limit
        logic               err_ok;    // position error under one slot
        logic [POS_W-1:0]   position;
        logic [ADV_W-1:0]   amount;
    } cmd_t;

    typedef struct packed {
        logic               valid;
        logic               full;
        logic [QCNT_W-1:0]  count;
    } queue_status_t;

    typedef struct packed {
        logic               jam;
        logic               out_valid;
    } back_status_t;

endpackage

[rtl/core/fmjr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feed motor jam recovery front end
// Keeps the current window and its running sum, tracks the single-shot
// trigger edge, and turns each accepted request into a command record.
// ----------------------------------------------------------------------------
module fmjr_front #(
    parameter int WINDOW_LEN = fmjr_pkg::WINDOW_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [1:0]                    kind,
    input  logic signed [15:0]            motor_current,
    input  logic [fmjr_pkg::POS_W-1:0]    measured_position,
    input  logic [fmjr_pkg::POS_W-1:0]    position_error,
    input  logic [fmjr_pkg::CNT_W-1:0]    shot_count,
    input  logic                          trigger_level,
    input  logic [fmjr_pkg::THR_W-1:0]    jam_threshold,
    input  logic [fmjr_pkg::STEP_W-1:0]   slot_step,
    output fmjr_pkg::cmd_t                cmd
);

    localparam int SUM_W   = 16 + $clog2(WINDOW_LEN);
    localparam int LIMIT_W = fmjr_pkg::THR_W + $clog2(WINDOW_LEN);
    localparam int CMP_W   = ((SUM_W > LIMIT_W) ? SUM_W : LIMIT_W) + 1;

    logic signed [15:0]       win_reg [WINDOW_LEN];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     single_en_reg;
    logic                     single_en_next;
    logic [SUM_W-1:0]         sum_mag;
    logic [LIMIT_W-1:0]       jam_limit;
    logic [fmjr_pkg::POS_W-1:0] err_mag;
    logic [fmjr_pkg::CNT_W-1:0] slots;
    logic                     is_tick;
    logic                     is_shot;

    assign is_tick = (kind == fmjr_pkg::KIND_TICK);
    assign is_shot = (kind == fmjr_pkg::KIND_SHOT);

    // Window sum after the new sample enters and the oldest one leaves.
    assign sum_next  = sum_reg - SUM_W'(win_reg[0]) + SUM_W'(motor_current);
    assign sum_mag   = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    assign jam_limit = LIMIT_W'(jam_threshold) * LIMIT_W'(WINDOW_LEN);

    // The magnitude of the most negative error still fits as unsigned.
    assign err_mag = position_error[fmjr_pkg::POS_W-1] ? (-position_error) : position_error;

    always_comb begin
        single_en_next = single_en_reg;
        if (trigger_level && single_en_reg) begin
            single_en_next = 1'b0;
        end else if (!trigger_level) begin
            single_en_next = 1'b1;
        end
    end

    always_comb begin
        cmd.over     = CMP_W'(sum_mag) > CMP_W'(jam_limit);
        cmd.err_ok   = err_mag < fmjr_pkg::POS_W'(slot_step);
        cmd.position = measured_position;
        slots        = (kind == fmjr_pkg::KIND_BURST) ? shot_count : fmjr_pkg::CNT_W'(1);
        cmd.amount   = fmjr_pkg::ADV_W'(slot_step) * fmjr_pkg::ADV_W'(slots);
        unique case (fmjr_pkg::kind_t'(kind))
            fmjr_pkg::KIND_TICK:  cmd.op = fmjr_pkg::CMD_TICK;
            fmjr_pkg::KIND_BURST: cmd.op = fmjr_pkg::CMD_ADVANCE;
            fmjr_pkg::KIND_SHOT: begin
                cmd.op = (trigger_level && single_en_reg) ? fmjr_pkg::CMD_ADVANCE
                                                          : fmjr_pkg::CMD_NONE;
            end
            default:              cmd.op = fmjr_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
            sum_reg       <= '0;
            single_en_reg <= 1'b1;
        end else if (accept) begin
            if (is_tick) begin
                for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WINDOW_LEN-1] <= motor_current;
                sum_reg               <= sum_next;
            end
            if (is_shot) begin
                single_en_reg <= single_en_next;
            end
        end
    end

endmodule

[rtl/core/fmjr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feed motor jam recovery command queue
// A small first-in first-out buffer of command records between the front
// end and the back end.
// ----------------------------------------------------------------------------
module fmjr_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  fmjr_pkg::cmd_t           push_cmd,
    input  logic                     pop,
    output fmjr_pkg::cmd_t           head_cmd,
    output fmjr_pkg::queue_status_t  status
);

    fmjr_pkg::cmd_t                 entry_reg [fmjr_pkg::QUEUE_DEPTH];
    logic [fmjr_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [fmjr_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [fmjr_pkg::QCNT_W-1:0]    count_reg;
    logic [fmjr_pkg::QCNT_W-1:0]    count_next;

    assign head_cmd      = entry_reg[rd_ptr_reg];
    assign status.valid  = (count_reg != '0);
    assign status.full   = (count_reg == fmjr_pkg::QCNT_W'(fmjr_pkg::QUEUE_DEPTH));
    assign status.count  = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/fmjr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feed motor jam recovery back end
// Holds the jam flag, recovery timer and setpoint, executes one command per
// cycle while pop is high and loads the result into the output register.
// ----------------------------------------------------------------------------
module fmjr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop,
    input  fmjr_pkg::cmd_t                cmd,
    input  logic                          out_ready,
    input  logic [fmjr_pkg::TICKS_W-1:0]  recovery_ticks,
    input  logic [fmjr_pkg::STEP_W-1:0]   return_step,
    output logic [fmjr_pkg::POS_W-1:0]    target_position,
    output logic                          target_written,
    output logic                          jam_active,
    output fmjr_pkg::back_status_t        status
);

    logic                          jam_reg;
    logic                          jam_next;
    logic [fmjr_pkg::TICKS_W-1:0]  timer_reg;
    logic [fmjr_pkg::TICKS_W-1:0]  timer_next;
    logic [fmjr_pkg::POS_W-1:0]    setpoint_reg;
    logic [fmjr_pkg::POS_W-1:0]    setpoint_next;
    logic                          written_next;
    logic                          out_valid_reg;
    logic [fmjr_pkg::POS_W-1:0]    out_pos_reg;
    logic                          out_written_reg;
    logic                          out_jam_reg;

    always_comb begin
        jam_next      = jam_reg;
        timer_next    = timer_reg;
        setpoint_next = setpoint_reg;
        written_next  = 1'b0;
        unique case (cmd.op)
            fmjr_pkg::CMD_TICK: begin
                if (jam_reg) begin
                    if (timer_reg < recovery_ticks) begin
                        timer_next = timer_reg + 1'b1;
                    end else begin
                        timer_next    = '0;
                        jam_next      = 1'b0;
                        setpoint_next = setpoint_reg + fmjr_pkg::POS_W'(return_step);
                        written_next  = 1'b1;
                    end
                end else if (cmd.over) begin
                    setpoint_next = cmd.position - fmjr_pkg::POS_W'(return_step);
                    jam_next      = 1'b1;
                    written_next  = 1'b1;
                end
            end
            fmjr_pkg::CMD_ADVANCE: begin
                if (!jam_reg && cmd.err_ok) begin
                    setpoint_next = setpoint_reg + fmjr_pkg::POS_W'(cmd.amount);
                    written_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jam_reg       <= 1'b0;
            timer_reg     <= '0;
            setpoint_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            jam_reg       <= jam_next;
            timer_reg     <= timer_next;
            setpoint_reg  <= setpoint_next;
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_pos_reg     <= setpoint_next;
            out_written_reg <= written_next;
            out_jam_reg     <= jam_next;
        end
    end

    assign target_position  = out_pos_reg;
    assign target_written   = out_written_reg;
    assign jam_active       = out_jam_reg;
    assign status.jam       = jam_reg;
    assign status.out_valid = out_valid_reg;

endmodule

[rtl/core/feed_motor_jam_recovery_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feed motor jam recovery unit
// Jam detector on a moving window of motor current, with the position
// setpoint keeper for burst and single-shot feed requests.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while its command queue is not
// full and returns exactly one result per request, in order. A command passes
// from the classifying front end into the command queue, and the back end then
// loads its result into the output register that drives the master side. The
// back end updates the jam flag, recovery timer and setpoint together, so a new
// command can start every cycle while the output register is empty or taken;
// the four-entry command queue absorbs stalls on the master side, and the
// slave side only stalls when the queue is full.
// Configuration writes are meant for idle periods and take effect at once.
module feed_motor_jam_recovery_unit #(
    parameter int WINDOW_LEN = fmjr_pkg::WINDOW_LEN_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] motor_current, [47:16] measured_position, [79:48] position_error,
    // [87:80] shot_count, [88] trigger_level, [95:89] zero
    input  logic [95:0]  s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] target_position, [32] target_written, [33] jam_active, [39:34] zero
    output logic [39:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [14:0]  cfg_wdata
);

    logic [fmjr_pkg::THR_W-1:0]    jam_threshold_reg;
    logic [fmjr_pkg::TICKS_W-1:0]  recovery_ticks_reg;
    logic [fmjr_pkg::STEP_W-1:0]   slot_step_reg;
    logic [fmjr_pkg::STEP_W-1:0]   return_step_reg;

    fmjr_pkg::cmd_t                front_cmd;
    fmjr_pkg::cmd_t                head_cmd;
    fmjr_pkg::queue_status_t       q_status;
    fmjr_pkg::back_status_t        b_status;
    logic                          accept;
    logic                          pop;
    logic [fmjr_pkg::POS_W-1:0]    target_position;
    logic                          target_written;
    logic                          jam_active;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jam_threshold_reg  <= fmjr_pkg::JAM_THRESHOLD_RST;
            recovery_ticks_reg <= fmjr_pkg::RECOVERY_TICKS_RST;
            slot_step_reg      <= fmjr_pkg::SLOT_STEP_RST;
            return_step_reg    <= fmjr_pkg::RETURN_STEP_RST;
        end else if (cfg_we) begin
            unique case (fmjr_pkg::reg_index_t'(cfg_addr))
                fmjr_pkg::REG_JAM_THRESHOLD:  jam_threshold_reg  <= cfg_wdata;
                fmjr_pkg::REG_RECOVERY_TICKS: recovery_ticks_reg <= cfg_wdata[7:0];
                fmjr_pkg::REG_SLOT_STEP:      slot_step_reg      <= cfg_wdata[9:0];
                fmjr_pkg::REG_RETURN_STEP:    return_step_reg    <= cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = q_status.valid && (!b_status.out_valid || m_axis_tready);

    fmjr_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .accept            (accept),
        .kind              (s_axis_tuser),
        .motor_current     (s_axis_tdata[15:0]),
        .measured_position (s_axis_tdata[47:16]),
        .position_error    (s_axis_tdata[79:48]),
        .shot_count        (s_axis_tdata[87:80]),
        .trigger_level     (s_axis_tdata[88]),
        .jam_threshold     (jam_threshold_reg),
        .slot_step         (slot_step_reg),
        .cmd               (front_cmd)
    );

    fmjr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    fmjr_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop             (pop),
        .cmd             (head_cmd),
        .out_ready       (m_axis_tready),
        .recovery_ticks  (recovery_ticks_reg),
        .return_step     (return_step_reg),
        .target_position (target_position),
        .target_written  (target_written),
        .jam_active      (jam_active),
        .status          (b_status)
    );

    assign m_axis_tvalid = b_status.out_valid;
    assign m_axis_tdata  = {6'b0, jam_active, target_written, target_position};

    // The queue fill level follows the request and command traffic exactly.
    a_queue_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
        (q_status.count == $past(q_status.count) + fmjr_pkg::QCNT_W'($past(accept))
                           - fmjr_pkg::QCNT_W'($past(pop))))
        else $error("command queue count out of step with push and pop");

    // A result waiting on the master side is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_status.out_valid && !m_axis_tready) |-> !pop)
        else $error("command executed while the output register was held");

    // The jam flag only moves when a command is executed.
    a_jam_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (b_status.jam != $past(b_status.jam))) |-> $past(pop))
        else $error("jam flag changed without a command");

    // A result that reports a new jam always carries a setpoint write.
    a_jam_written: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(b_status.jam)) |-> (m_axis_tvalid && target_written))
        else $error("jam entry without a setpoint write");

endmodule

[bench/feed_motor_jam_recovery_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feed motor jam recovery unit testbench
// Drives tick, burst, single-shot and unused-kind requests into the unit and
// keeps its own model of the current window, the jam recovery and the setpoint.
// A short table of directed requests comes first. Six random phases follow,
// each with its own register settings; successive pairs of phases share one
// handshake pressure. Every result is checked field by field, in order.
// ----------------------------------------------------------------------------
module feed_motor_jam_recovery_unit_test;

    localparam int WINDOW          = fmjr_pkg::WINDOW_LEN_DEF;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] target;
        logic        written;
        logic        jam;
    } setpoint_result_t;

    typedef struct packed {
        logic             valid;
        setpoint_result_t res;
    } typed_result_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] cur;
        logic [31:0] pos;
        logic [31:0] err;
        logic [7:0]  cnt;
        logic        lvl;
        logic        typed;
        logic [31:0] tgt;
        logic        wr;
        logic        jam;
    } stim_row_t;

    // Rows with typed = 1 carry a result that follows from the reset settings.
    localparam stim_row_t DIRECTED_ROWS [21] = '{
        '{fmjr_pkg::KIND_BURST, 16'h0, 32'h0, 32'h0, 8'd1, 1'b0,
          1'b1, 32'd18, 1'b1, 1'b0},
        '{fmjr_pkg::KIND_BURST, 16'h0, 32'h0, 32'd18, 8'd5, 1'b0,
          1'b1, 32'd18, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_BURST, 16'hFFFF, 32'h0, 32'hFFFF_FFEF, 8'd255, 1'b0,
          1'b1, 32'd4608, 1'b1, 1'b0},
        '{fmjr_pkg::KIND_SHOT, 16'h0, 32'h0, 32'h0, 8'd0, 1'b1,
          1'b1, 32'd4626, 1'b1, 1'b0},
        '{fmjr_pkg::KIND_SHOT, 16'h0, 32'h0, 32'h0, 8'd0, 1'b1,
          1'b1, 32'd4626, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_SHOT, 16'h0, 32'h0, 32'h0, 8'd0, 1'b0,
          1'b1, 32'd4626, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_SHOT, 16'h0, 32'h0, 32'h8000_0000, 8'd0, 1'b1,
          1'b1, 32'd4626, 1'b0, 1'b0},
        '{KIND_UNUSED, 16'h7FFF, 32'hFFFF_FFFF, 32'h0, 8'd255, 1'b1,
          1'b1, 32'd4626, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_BURST, 16'h0, 32'h0, 32'h7FFF_FFFF, 8'd255, 1'b0,
          1'b1, 32'd4626, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_BURST, 16'h0, 32'h0, 32'h0, 8'd0, 1'b0,
          1'b1, 32'd4626, 1'b1, 1'b0},
        '{fmjr_pkg::KIND_TICK, 16'h7FFF, 32'h0, 32'h0, 8'd0, 1'b0,
          1'b1, 32'd4626, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_TICK, 16'h7FFF, 32'h8000_0000, 32'h0, 8'd0, 1'b0,
          1'b1, 32'h7FFF_FFF7, 1'b1, 1'b1},
        '{fmjr_pkg::KIND_BURST, 16'h0, 32'h0, 32'h0, 8'd1, 1'b0,
          1'b1, 32'h7FFF_FFF7, 1'b0, 1'b1},
        '{fmjr_pkg::KIND_SHOT, 16'h0, 32'h0, 32'h0, 8'd0, 1'b0,
          1'b0, 32'h0, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_SHOT, 16'h0, 32'h0, 32'h0, 8'd0, 1'b1,
          1'b0, 32'h0, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_TICK, 16'h8000, 32'h7FFF_FFFF, 32'h0, 8'd0, 1'b0,
          1'b0, 32'h0, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_TICK, 16'h8000, 32'h0, 32'h0, 8'd0, 1'b0,
          1'b0, 32'h0, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_TICK, 16'h8000, 32'h0, 32'h0, 8'd0, 1'b0,
          1'b0, 32'h0, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_TICK, 16'h8000, 32'h0, 32'h0, 8'd0, 1'b0,
          1'b0, 32'h0, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_TICK, 16'h8000, 32'h0, 32'h0, 8'd0, 1'b0,
          1'b0, 32'h0, 1'b0, 1'b0},
        '{fmjr_pkg::KIND_SHOT, 16'h0, 32'h0, 32'h0, 8'd0, 1'b0,
          1'b0, 32'h0, 1'b0, 1'b0}
    };

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_addr      = '0;
    logic [14:0] cfg_wdata     = '0;

    // Model state and its copy of the registers.
    logic signed [15:0] window_q [WINDOW];
    int                 window_sum_q;
    logic               jam_q;
    logic [7:0]         recovery_timer_q;
    logic [31:0]        setpoint_q;
    logic               single_enable_q;
    logic [14:0]        jam_threshold_q;
    logic [7:0]         recovery_ticks_q;
    logic [9:0]         slot_step_q;
    logic [9:0]         return_step_q;

    setpoint_result_t expected_setpoints [$];
    typed_result_t    typed_setpoints [$];
    int               error_count  = 0;
    int               stall_cycles = 0;
    int               src_idle_pct = 0;
    int               sink_idle_pct = 0;

    feed_motor_jam_recovery_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [95:0] pack_request(input logic [15:0] cur,
                                                 input logic [31:0] pos,
                                                 input logic [31:0] err,
                                                 input logic [7:0] cnt,
                                                 input logic lvl);
        return {7'b0, lvl, cnt, err, pos, cur};
    endfunction

    // Advance the setpoint by n slots when not jammed and the error is under one slot.
    function automatic logic try_advance(input logic [31:0] err, input logic [7:0] n);
        longint mag;
        if (jam_q) return 1'b0;
        mag = longint'($signed(err));
        if (mag < 0) mag = -mag;
        if (mag < longint'(slot_step_q)) begin
            setpoint_q = setpoint_q + slot_step_q * n;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_setpoint(input logic [1:0] kind, input logic [95:0] d,
                                    output setpoint_result_t res);
        logic signed [15:0] sample;
        int                 mag;
        logic               written;
        written = 1'b0;
        case (kind)
            fmjr_pkg::KIND_TICK: begin
                sample = $signed(d[15:0]);
                window_sum_q = window_sum_q - window_q[0];
                for (int i = 0; i < WINDOW - 1; i++) window_q[i] = window_q[i + 1];
                window_q[WINDOW - 1] = sample;
                window_sum_q = window_sum_q + sample;
                if (jam_q) begin
                    if (recovery_timer_q < recovery_ticks_q) begin
                        recovery_timer_q = recovery_timer_q + 8'd1;
                    end else begin
                        recovery_timer_q = 8'd0;
                        jam_q = 1'b0;
                        setpoint_q = setpoint_q + return_step_q;
                        written = 1'b1;
                    end
                end else begin
                    mag = (window_sum_q < 0) ? -window_sum_q : window_sum_q;
                    if (mag > int'(jam_threshold_q) * WINDOW) begin
                        setpoint_q = d[47:16] - return_step_q;
                        jam_q = 1'b1;
                        written = 1'b1;
                    end
                end
            end
            fmjr_pkg::KIND_BURST: written = try_advance(d[79:48], d[87:80]);
            fmjr_pkg::KIND_SHOT: begin
                if (d[88] && single_enable_q) begin
                    single_enable_q = 1'b0;
                    written = try_advance(d[79:48], 8'd1);
                end else if (!d[88]) begin
                    single_enable_q = 1'b1;
                end
            end
            default: ;
        endcase
        res.target  = setpoint_q;
        res.written = written;
        res.jam     = jam_q;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Model update, result check and stall count, all on the sampled values.
    always @(posedge aclk) begin : monitor_blk
        setpoint_result_t want;
        typed_result_t    typed;
        logic             moved;
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) window_q[i] = '0;
            window_sum_q     = 0;
            jam_q            = 1'b0;
            recovery_timer_q = 8'd0;
            setpoint_q       = 32'd0;
            single_enable_q  = 1'b1;
            jam_threshold_q  = fmjr_pkg::JAM_THRESHOLD_RST;
            recovery_ticks_q = fmjr_pkg::RECOVERY_TICKS_RST;
            slot_step_q      = fmjr_pkg::SLOT_STEP_RST;
            return_step_q    = fmjr_pkg::RETURN_STEP_RST;
            stall_cycles     = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    fmjr_pkg::REG_JAM_THRESHOLD:  jam_threshold_q  = cfg_wdata[14:0];
                    fmjr_pkg::REG_RECOVERY_TICKS: recovery_ticks_q = cfg_wdata[7:0];
                    fmjr_pkg::REG_SLOT_STEP:      slot_step_q      = cfg_wdata[9:0];
                    fmjr_pkg::REG_RETURN_STEP:    return_step_q    = cfg_wdata[9:0];
                    default: ;
                endcase
            end
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_setpoint(s_axis_tuser, s_axis_tdata, want);
                typed = typed_setpoints.pop_front();
                if (typed.valid) want = typed.res;
                expected_setpoints.push_back(want);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                if (expected_setpoints.size() == 0) begin
                    report_mismatch("result with no request waiting", m_axis_tdata[31:0],
                                    32'h0);
                end else begin
                    want = expected_setpoints.pop_front();
                    if (m_axis_tdata[31:0] !== want.target)
                        report_mismatch("target_position", m_axis_tdata[31:0], want.target);
                    if (m_axis_tdata[32] !== want.written)
                        report_mismatch("target_written", {31'b0, m_axis_tdata[32]},
                                        {31'b0, want.written});
                    if (m_axis_tdata[33] !== want.jam)
                        report_mismatch("jam_active", {31'b0, m_axis_tdata[33]},
                                        {31'b0, want.jam});
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("feed_motor_jam_recovery_unit_test: done, errors");
        $finish;
    end

    // Presents one request, with random idle cycles ahead of it, and returns
    // at the edge where it is accepted.
    task automatic push_request(input logic [1:0] kind, input logic [95:0] d,
                                input typed_result_t typed);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        typed_setpoints.push_back(typed);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= d;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Waits until every request has come back, then lets the pipeline settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_setpoints.size() != 0 || typed_setpoints.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [14:0] thr, input logic [7:0] ticks,
                                  input logic [9:0] slot, input logic [9:0] ret);
        cfg_we    <= 1'b1;
        cfg_addr  <= fmjr_pkg::REG_JAM_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_addr  <= fmjr_pkg::REG_RECOVERY_TICKS;
        cfg_wdata <= {7'b0, ticks};
        @(posedge aclk);
        cfg_addr  <= fmjr_pkg::REG_SLOT_STEP;
        cfg_wdata <= {5'b0, slot};
        @(posedge aclk);
        cfg_addr  <= fmjr_pkg::REG_RETURN_STEP;
        cfg_wdata <= {5'b0, ret};
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        typed_result_t typed;
        stim_row_t     row;
        logic [14:0]   thr;
        logic [7:0]    ticks;
        logic [9:0]    slot;
        logic [9:0]    ret;
        logic [1:0]    kind;
        logic [15:0]   cur;
        logic [31:0]   pos;
        logic [31:0]   err;
        int            load;
        int            span;
        int            mag;
        int            e;
        int            counted;
        int            r;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 35;
        sink_idle_pct = 55;
        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            typed.valid       = row.typed;
            typed.res.target  = row.tgt;
            typed.res.written = row.wr;
            typed.res.jam     = row.jam;
            push_request(row.kind, pack_request(row.cur, row.pos, row.err, row.cnt, row.lvl),
                         typed);
        end

        typed = '0;
        load  = 0;
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    thr = 15'd0; ticks = 8'd0; slot = 10'd1023; ret = 10'd1023;
                end
                2: begin
                    thr = 15'd32767; ticks = 8'd255; slot = 10'd0; ret = 10'd0;
                end
                5: begin
                    thr   = 15'($urandom);
                    ticks = 8'($urandom);
                    slot  = 10'($urandom);
                    ret   = 10'($urandom);
                end
                default: begin
                    thr   = 15'($urandom_range(3000, 200));
                    ticks = 8'($urandom_range(12));
                    slot  = 10'($urandom_range(1023, 1));
                    ret   = 10'($urandom_range(1023));
                end
            endcase
            write_settings(thr, ticks, slot, ret);
            src_idle_pct  = (phase < 2) ? 35 : (phase < 4) ? 55 : 0;
            sink_idle_pct = (phase < 2) ? 55 : (phase < 4) ? 35 : 0;
            span = 2 * int'(thr) + 50;
            if (span > 32767) span = 32767;

            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                // The motor load wanders between quiet and heavy in either
                // direction, so the window sum climbs past the limit and falls back.
                if ($urandom_range(99) < 4) load = $urandom_range(2);
                r = $urandom_range(99);
                kind = (r < 50) ? fmjr_pkg::KIND_TICK : (r < 75) ? fmjr_pkg::KIND_BURST :
                       (r < 95) ? fmjr_pkg::KIND_SHOT : KIND_UNUSED;
                case ($urandom_range(3))
                    0: cur = 16'($urandom);
                    1: cur = (load == 0) ? 16'h0 : (load == 2) ? 16'h8000 : 16'h7FFF;
                    default: begin
                        mag = (load == 0) ? $urandom_range(50) : $urandom_range(span);
                        cur = 16'((load == 2) ? -mag : mag);
                    end
                endcase
                case ($urandom_range(9))
                    0: pos = 32'h8000_0000 + $urandom_range(1023);
                    1: pos = 32'h7FFF_FFFF - $urandom_range(1023);
                    default: pos = $urandom;
                endcase
                e = $urandom_range(int'(slot) + 1);
                case ($urandom_range(9))
                    0: err = 32'h8000_0000;
                    1: err = 32'h7FFF_FFFF;
                    2, 3: err = $urandom;
                    default: err = $urandom_range(1) ? -e : e;
                endcase
                push_request(kind, pack_request(cur, pos, err, 8'($urandom),
                                                1'($urandom)), typed);
                if (kind != KIND_UNUSED) counted++;
            end
        end

        drain_results();
        if (error_count == 0) begin
            $display("feed_motor_jam_recovery_unit_test: done, clean");
        end else begin
            $display("feed_motor_jam_recovery_unit_test: done, errors");
        end
        $finish;
    end

endmodule

[feed_motor_jam_recovery_unit.f]
rtl/core/fmjr_pkg.sv
rtl/core/fmjr_front.sv
rtl/core/fmjr_queue.sv
rtl/core/fmjr_back.sv
rtl/core/feed_motor_jam_recovery_unit.sv
bench/feed_motor_jam_recovery_unit_test.sv
